// ===== rtl/core/lur_pkg.sv =====
package lur_pkg;

    localparam int FRAME_WIDTH_DEF  = 640;
    localparam int FRAME_HEIGHT_DEF = 480;

    localparam int COL_W     = 10;
    localparam int ROW_W     = 9;
    localparam int VAL_W     = 8;
    localparam int FIX_W     = 20;
    localparam int COEF_W    = 32;
    localparam int CFG_IDX_W = 3;

    localparam int DIFF_W    = FIX_W + 1;
    localparam int NORM_W    = 27;
    localparam int DIV_STEPS = NORM_W - 1;
    localparam int NORM_LAT  = DIV_STEPS + 2;
    localparam int NORM_MAX  = (1 << (NORM_W - 1)) - 1;

    localparam logic [FIX_W-1:0] FOCAL_X_RST  = FIX_W'(117415);
    localparam logic [FIX_W-1:0] FOCAL_Y_RST  = FIX_W'(117068);
    localparam logic [FIX_W-1:0] CENTRE_X_RST = FIX_W'(94007);
    localparam logic [FIX_W-1:0] CENTRE_Y_RST = FIX_W'(63584);

    typedef enum logic {
        KIND_LOAD,
        KIND_COMPUTE
    } kind_e;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_K1,
        REG_K2,
        REG_P1,
        REG_P2,
        REG_FX,
        REG_FY,
        REG_CX,
        REG_CY
    } cfg_idx_e;

    typedef struct packed {
        kind_e              kind;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [VAL_W-1:0]   val;
    } item_t;

    typedef struct packed {
        logic [DIFF_W-1:0]    rem;
        logic [1:0]           low;
        logic [DIV_STEPS-1:0] quo;
        logic                 neg;
        logic                 ovf;
    } div_stage_t;

endpackage

// ===== rtl/core/lens_undistort_remap.sv =====
// Channel   Handshake                 Payload
// input     start, busy               kind, pixel_col, pixel_row, pixel_value
// result    done (one-cycle strobe)   source_inside, nearest_value, mean_value
// config    cfg_valid, cfg_ready      cfg_index, cfg_data
//
// One word is accepted every clock cycle; busy stays low.
// A compute word's result is formed by the 26-step pipelined divider and the
// fixed-point multiply chain.
// The frame store is four single-port-read banks, one per row/column parity.
// Reset clears control and presets config; the store needs no clearing pass.
// The receiver cannot stall; results are strobed on done.
module lens_undistort_remap #(
    parameter int FRAME_WIDTH  = lur_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = lur_pkg::FRAME_HEIGHT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              kind,
    input  logic [lur_pkg::COL_W-1:0]         pixel_col,
    input  logic [lur_pkg::ROW_W-1:0]         pixel_row,
    input  logic [lur_pkg::VAL_W-1:0]         pixel_value,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lur_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lur_pkg::COEF_W-1:0]        cfg_data,
    output logic                              done,
    output logic                              source_inside,
    output logic [lur_pkg::VAL_W-1:0]         nearest_value,
    output logic [lur_pkg::VAL_W-1:0]         mean_value
);
    import lur_pkg::*;

    localparam int CW         = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
    localparam int RW         = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
    localparam int HALF_W     = (FRAME_WIDTH + 1) / 2;
    localparam int HALF_H     = (FRAME_HEIGHT + 1) / 2;
    localparam int BANK_DEPTH = HALF_W * HALF_H;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    localparam logic signed [43:0] RAD_ONE = 44'sd16777216;
    localparam logic signed [43:0] RAD_LIM = 44'sd68719476736;

    // configuration
    logic signed [COEF_W-1:0] k1_reg, k2_reg, p1_reg, p2_reg;
    logic [FIX_W-1:0]         fx_reg, fy_reg, cx_reg, cy_reg;
    logic [FIX_W-1:0]         fx_eff, fy_eff;

    // entry and alignment line
    logic  in_valid_reg;
    item_t in_item_reg;
    logic  dly_valid_reg [NORM_LAT];
    item_t dly_item_reg  [NORM_LAT];
    logic signed [NORM_W-1:0] x_norm, y_norm;

    // arithmetic stages
    logic  s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic  s6_valid_reg, s7_valid_reg, s8_valid_reg, s9_valid_reg, s10_valid_reg;
    logic  s11_valid_reg;
    item_t s1_item_reg, s2_item_reg, s3_item_reg, s4_item_reg, s5_item_reg;
    item_t s6_item_reg, s7_item_reg, s8_item_reg, s9_item_reg;

    logic signed [53:0] prod_xx, prod_yy, prod_xy;
    logic signed [NORM_W-1:0] s1_x_reg, s1_y_reg, s2_x_reg, s2_y_reg, s3_x_reg, s3_y_reg;
    logic signed [NORM_W-1:0] s4_x_reg, s4_y_reg, s5_x_reg, s5_y_reg;
    logic signed [29:0] s1_x2_reg, s1_y2_reg, s1_xy_reg, s2_xy_reg;

    logic signed [30:0] s2_r2_next, s2_r2_reg, s3_r2_reg;
    logic signed [31:0] s2_tpx_next, s2_tpy_next, s2_tpx_reg, s2_tpy_reg;

    logic signed [62:0] prod_a, prod_b;
    logic signed [61:0] prod_t1, prod_t2;
    logic signed [63:0] prod_t3, prod_t4;
    logic signed [34:0] s3_a_reg, s3_b_reg, s4_a_reg;
    logic signed [33:0] s3_t1_reg, s3_t2_reg, s4_t1_reg, s4_t2_reg, s5_t1_reg, s5_t2_reg;
    logic signed [33:0] s6_t1_reg, s6_t2_reg;
    logic signed [35:0] s3_t3_reg, s3_t4_reg, s4_t3_reg, s4_t4_reg, s5_t3_reg, s5_t4_reg;
    logic signed [35:0] s6_t3_reg, s6_t4_reg;

    logic signed [65:0] prod_c;
    logic signed [41:0] s4_c_reg;

    logic signed [43:0] rad_sum;
    logic signed [37:0] rad_next, s5_rad_reg;

    logic signed [46:0] prod_xlo, prod_ylo, s6_xlo_reg, s6_ylo_reg;
    logic signed [45:0] prod_xhi, prod_yhi, s6_xhi_reg, s6_yhi_reg;

    logic signed [65:0] xr_full, yr_full;
    logic signed [41:0] xd_next, yd_next, s7_xd_reg, s7_yd_reg;

    logic signed [FIX_W:0] fx_s, fy_s;
    logic signed [42:0] prod_ulo, prod_vlo, s8_ulo_reg, s8_vlo_reg;
    logic signed [41:0] prod_uhi, prod_vhi, s8_uhi_reg, s8_vhi_reg;

    logic signed [65:0] ud_next, vd_next, s9_ud_reg, s9_vd_reg;

    // frame store access
    logic            src_inside, load_ok;
    logic            hit_next;
    logic [CW-1:0]   c0_next;
    logic [RW-1:0]   r0_next;
    kind_e           s10_kind_reg;
    logic [VAL_W-1:0] s10_val_reg;
    logic            s10_hit_reg, s10_c_last_reg, s10_r_last_reg;
    logic [CW-1:0]   s10_c0_reg;
    logic [RW-1:0]   s10_r0_reg;

    logic [CW-1:0]      col_sel [2];
    logic [RW-1:0]      row_sel [2];
    logic [BANK_AW-1:0] row_base [2];
    logic [BANK_AW-1:0] col_off [2];
    logic [BANK_AW-1:0] bank_addr [4];
    logic [3:0]         bank_we;
    logic [VAL_W-1:0]   bank_rd_reg [4];

    kind_e s11_kind_reg;
    logic  s11_hit_reg, s11_rp_reg, s11_cp_reg, s11_c_last_reg, s11_r_last_reg;

    logic [1:0]       i00, i01, i10, i11;
    logic [VAL_W-1:0] p00, p01, p10, p11;
    logic [VAL_W+1:0] pix_sum;
    logic             done_next, inside_next;
    logic [VAL_W-1:0] nearest_next, mean_next;
    logic             done_reg, inside_reg;
    logic [VAL_W-1:0] nearest_reg, mean_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign fx_eff    = (fx_reg == '0) ? FIX_W'(1) : fx_reg;
    assign fy_eff    = (fy_reg == '0) ? FIX_W'(1) : fy_reg;

    lur_norm #(.PIX_W(COL_W)) u_norm_x (
        .clk    (clk),
        .pixel  (in_item_reg.col),
        .centre (cx_reg),
        .focal  (fx_eff),
        .norm   (x_norm)
    );

    lur_norm #(.PIX_W(ROW_W)) u_norm_y (
        .clk    (clk),
        .pixel  (in_item_reg.row),
        .centre (cy_reg),
        .focal  (fy_eff),
        .norm   (y_norm)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k1_reg <= '0;
            k2_reg <= '0;
            p1_reg <= '0;
            p2_reg <= '0;
            fx_reg <= FOCAL_X_RST;
            fy_reg <= FOCAL_Y_RST;
            cx_reg <= CENTRE_X_RST;
            cy_reg <= CENTRE_Y_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_e'(cfg_index))
                REG_K1: k1_reg <= cfg_data;
                REG_K2: k2_reg <= cfg_data;
                REG_P1: p1_reg <= cfg_data;
                REG_P2: p2_reg <= cfg_data;
                REG_FX: fx_reg <= cfg_data[FIX_W-1:0];
                REG_FY: fy_reg <= cfg_data[FIX_W-1:0];
                REG_CX: cx_reg <= cfg_data[FIX_W-1:0];
                REG_CY: cy_reg <= cfg_data[FIX_W-1:0];
            endcase
        end
    end

    // arithmetic
    always_comb
    begin
        prod_xx = x_norm * x_norm;
        prod_yy = y_norm * y_norm;
        prod_xy = x_norm * y_norm;

        s2_r2_next  = 31'(s1_x2_reg) + 31'(s1_y2_reg);
        s2_tpx_next = 32'(s1_x2_reg) + 32'(s1_x2_reg) + 32'(s1_x2_reg) + 32'(s1_y2_reg);
        s2_tpy_next = 32'(s1_y2_reg) + 32'(s1_y2_reg) + 32'(s1_y2_reg) + 32'(s1_x2_reg);

        prod_a  = k1_reg * s2_r2_reg;
        prod_b  = k2_reg * s2_r2_reg;
        prod_t1 = p1_reg * s2_xy_reg;
        prod_t2 = p2_reg * s2_xy_reg;
        prod_t3 = p2_reg * s2_tpx_reg;
        prod_t4 = p1_reg * s2_tpy_reg;

        prod_c = s3_b_reg * s3_r2_reg;

        rad_sum = 44'(s4_a_reg) + 44'(s4_c_reg) + RAD_ONE;
        if (rad_sum > RAD_LIM)
            rad_next = 38'(RAD_LIM);
        else if (rad_sum < -RAD_LIM)
            rad_next = 38'(-RAD_LIM);
        else
            rad_next = 38'(rad_sum);

        prod_xlo = s5_x_reg * $signed({1'b0, s5_rad_reg[18:0]});
        prod_xhi = s5_x_reg * $signed(s5_rad_reg[37:19]);
        prod_ylo = s5_y_reg * $signed({1'b0, s5_rad_reg[18:0]});
        prod_yhi = s5_y_reg * $signed(s5_rad_reg[37:19]);

        xr_full = (66'(s6_xhi_reg) <<< 19) + 66'(s6_xlo_reg);
        yr_full = (66'(s6_yhi_reg) <<< 19) + 66'(s6_ylo_reg);
        xd_next = 42'(xr_full[65:24]) + (42'(s6_t1_reg) <<< 1) + 42'(s6_t3_reg);
        yd_next = 42'(yr_full[65:24]) + 42'(s6_t4_reg) + (42'(s6_t2_reg) <<< 1);

        fx_s     = $signed({1'b0, fx_eff});
        fy_s     = $signed({1'b0, fy_eff});
        prod_ulo = fx_s * $signed({1'b0, s7_xd_reg[20:0]});
        prod_uhi = fx_s * $signed(s7_xd_reg[41:21]);
        prod_vlo = fy_s * $signed({1'b0, s7_yd_reg[20:0]});
        prod_vhi = fy_s * $signed(s7_yd_reg[41:21]);

        ud_next = (66'(s8_uhi_reg) <<< 21) + 66'(s8_ulo_reg) + (66'(cx_reg) <<< 24);
        vd_next = (66'(s8_vhi_reg) <<< 21) + 66'(s8_vlo_reg) + (66'(cy_reg) <<< 24);
    end

    // source position and store address
    always_comb
    begin
        src_inside = !s9_ud_reg[65] && !s9_vd_reg[65]
                     && (s9_ud_reg[65:32] < 34'(FRAME_WIDTH))
                     && (s9_vd_reg[65:32] < 34'(FRAME_HEIGHT));
        load_ok    = (32'(s9_item_reg.col) < 32'(FRAME_WIDTH))
                     && (32'(s9_item_reg.row) < 32'(FRAME_HEIGHT));
        if (s9_item_reg.kind == KIND_COMPUTE)
        begin
            hit_next = src_inside;
            c0_next  = s9_ud_reg[32 +: CW];
            r0_next  = s9_vd_reg[32 +: RW];
        end
        else
        begin
            hit_next = load_ok;
            c0_next  = CW'(s9_item_reg.col);
            r0_next  = RW'(s9_item_reg.row);
        end
    end

    always_comb
    begin
        for (int p = 0; p < 2; p++)
        begin
            col_sel[p]  = (s10_c0_reg[0] == p[0] || s10_c_last_reg) ? s10_c0_reg
                                                                    : s10_c0_reg + CW'(1);
            row_sel[p]  = (s10_r0_reg[0] == p[0] || s10_r_last_reg) ? s10_r0_reg
                                                                    : s10_r0_reg + RW'(1);
            row_base[p] = BANK_AW'(row_sel[p] >> 1) * BANK_AW'(HALF_W);
            col_off[p]  = BANK_AW'(col_sel[p] >> 1);
        end
        for (int b = 0; b < 4; b++)
        begin
            bank_addr[b] = row_base[b / 2] + col_off[b % 2];
            bank_we[b]   = s10_valid_reg && (s10_kind_reg == KIND_LOAD) && s10_hit_reg
                           && (s10_r0_reg[0] == b[1]) && (s10_c0_reg[0] == b[0]);
        end
    end

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [VAL_W-1:0] mem [BANK_DEPTH];

        always_ff @(posedge clk)
        begin
            if (bank_we[b])
            begin
                mem[bank_addr[b]] <= s10_val_reg;
            end
            bank_rd_reg[b] <= mem[bank_addr[b]];
        end
    end

    // neighborhood and result
    always_comb
    begin
        i00 = {s11_rp_reg, s11_cp_reg};
        i01 = {s11_rp_reg, ~s11_cp_reg};
        i10 = {~s11_rp_reg, s11_cp_reg};
        i11 = {~s11_rp_reg, ~s11_cp_reg};
        p00 = bank_rd_reg[i00];
        p01 = s11_c_last_reg ? p00 : bank_rd_reg[i01];
        p10 = s11_r_last_reg ? p00 : bank_rd_reg[i10];
        p11 = s11_c_last_reg ? p10 : (s11_r_last_reg ? p01 : bank_rd_reg[i11]);
        pix_sum = (VAL_W+2)'(p00) + (VAL_W+2)'(p01) + (VAL_W+2)'(p10) + (VAL_W+2)'(p11);

        done_next    = s11_valid_reg && (s11_kind_reg == KIND_COMPUTE);
        inside_next  = s11_hit_reg;
        nearest_next = s11_hit_reg ? p00 : '0;
        mean_next    = s11_hit_reg ? pix_sum[VAL_W+1:2] : '0;
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            for (int k = 0; k < NORM_LAT; k++)
            begin
                dly_valid_reg[k] <= 1'b0;
            end
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            s8_valid_reg  <= 1'b0;
            s9_valid_reg  <= 1'b0;
            s10_valid_reg <= 1'b0;
            s11_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            in_valid_reg     <= start && !busy;
            dly_valid_reg[0] <= in_valid_reg;
            for (int k = 1; k < NORM_LAT; k++)
            begin
                dly_valid_reg[k] <= dly_valid_reg[k-1];
            end
            s1_valid_reg  <= dly_valid_reg[NORM_LAT-1];
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5_valid_reg;
            s7_valid_reg  <= s6_valid_reg;
            s8_valid_reg  <= s7_valid_reg;
            s9_valid_reg  <= s8_valid_reg;
            s10_valid_reg <= s9_valid_reg;
            s11_valid_reg <= s10_valid_reg;
            done_reg      <= done_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        in_item_reg <= '{kind: kind_e'(kind), col: pixel_col, row: pixel_row,
                         val: pixel_value};
        dly_item_reg[0] <= in_item_reg;
        for (int k = 1; k < NORM_LAT; k++)
        begin
            dly_item_reg[k] <= dly_item_reg[k-1];
        end

        s1_item_reg <= dly_item_reg[NORM_LAT-1];
        s1_x_reg    <= x_norm;
        s1_y_reg    <= y_norm;
        s1_x2_reg   <= prod_xx[53:24];
        s1_y2_reg   <= prod_yy[53:24];
        s1_xy_reg   <= prod_xy[53:24];

        s2_item_reg <= s1_item_reg;
        s2_x_reg    <= s1_x_reg;
        s2_y_reg    <= s1_y_reg;
        s2_xy_reg   <= s1_xy_reg;
        s2_r2_reg   <= s2_r2_next;
        s2_tpx_reg  <= s2_tpx_next;
        s2_tpy_reg  <= s2_tpy_next;

        s3_item_reg <= s2_item_reg;
        s3_x_reg    <= s2_x_reg;
        s3_y_reg    <= s2_y_reg;
        s3_r2_reg   <= s2_r2_reg;
        s3_a_reg    <= prod_a[62:28];
        s3_b_reg    <= prod_b[62:28];
        s3_t1_reg   <= prod_t1[61:28];
        s3_t2_reg   <= prod_t2[61:28];
        s3_t3_reg   <= prod_t3[63:28];
        s3_t4_reg   <= prod_t4[63:28];

        s4_item_reg <= s3_item_reg;
        s4_x_reg    <= s3_x_reg;
        s4_y_reg    <= s3_y_reg;
        s4_a_reg    <= s3_a_reg;
        s4_c_reg    <= prod_c[65:24];
        s4_t1_reg   <= s3_t1_reg;
        s4_t2_reg   <= s3_t2_reg;
        s4_t3_reg   <= s3_t3_reg;
        s4_t4_reg   <= s3_t4_reg;

        s5_item_reg <= s4_item_reg;
        s5_x_reg    <= s4_x_reg;
        s5_y_reg    <= s4_y_reg;
        s5_rad_reg  <= rad_next;
        s5_t1_reg   <= s4_t1_reg;
        s5_t2_reg   <= s4_t2_reg;
        s5_t3_reg   <= s4_t3_reg;
        s5_t4_reg   <= s4_t4_reg;

        s6_item_reg <= s5_item_reg;
        s6_xlo_reg  <= prod_xlo;
        s6_xhi_reg  <= prod_xhi;
        s6_ylo_reg  <= prod_ylo;
        s6_yhi_reg  <= prod_yhi;
        s6_t1_reg   <= s5_t1_reg;
        s6_t2_reg   <= s5_t2_reg;
        s6_t3_reg   <= s5_t3_reg;
        s6_t4_reg   <= s5_t4_reg;

        s7_item_reg <= s6_item_reg;
        s7_xd_reg   <= xd_next;
        s7_yd_reg   <= yd_next;

        s8_item_reg <= s7_item_reg;
        s8_ulo_reg  <= prod_ulo;
        s8_uhi_reg  <= prod_uhi;
        s8_vlo_reg  <= prod_vlo;
        s8_vhi_reg  <= prod_vhi;

        s9_item_reg <= s8_item_reg;
        s9_ud_reg   <= ud_next;
        s9_vd_reg   <= vd_next;

        s10_kind_reg   <= s9_item_reg.kind;
        s10_val_reg    <= s9_item_reg.val;
        s10_hit_reg    <= hit_next;
        s10_c0_reg     <= c0_next;
        s10_r0_reg     <= r0_next;
        s10_c_last_reg <= (c0_next == CW'(FRAME_WIDTH - 1));
        s10_r_last_reg <= (r0_next == RW'(FRAME_HEIGHT - 1));

        s11_kind_reg   <= s10_kind_reg;
        s11_hit_reg    <= s10_hit_reg;
        s11_rp_reg     <= s10_r0_reg[0];
        s11_cp_reg     <= s10_c0_reg[0];
        s11_c_last_reg <= s10_c_last_reg;
        s11_r_last_reg <= s10_r_last_reg;

        inside_reg  <= inside_next;
        nearest_reg <= nearest_next;
        mean_reg    <= mean_next;
    end

    assign done          = done_reg;
    assign source_inside = inside_reg;
    assign nearest_value = nearest_reg;
    assign mean_value    = mean_reg;

    a_one_bank_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(bank_we))
        else $error("more than one frame bank written");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s11_valid_reg && s11_kind_reg == KIND_LOAD) |=> !done_reg)
        else $error("load word produced a result");

    a_hit_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (s10_valid_reg && s10_hit_reg) |->
            (32'(s10_c0_reg) < 32'(FRAME_WIDTH) && 32'(s10_r0_reg) < 32'(FRAME_HEIGHT)))
        else $error("store access outside frame");

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !inside_reg) |-> (nearest_reg == '0 && mean_reg == '0))
        else $error("outside source gave nonzero pixels");

endmodule

// ===== rtl/core/lur_norm.sv =====
module lur_norm #(
    parameter int PIX_W = lur_pkg::COL_W
) (
    input  logic                              clk,
    input  logic [PIX_W-1:0]                  pixel,
    input  logic [lur_pkg::FIX_W-1:0]         centre,
    input  logic [lur_pkg::FIX_W-1:0]         focal,
    output logic signed [lur_pkg::NORM_W-1:0] norm
);
    import lur_pkg::*;

    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        mag;
    div_stage_t               stage_next;
    div_stage_t               stage_reg [DIV_STEPS+1];
    logic [NORM_W-1:0]        mag_q;
    logic signed [NORM_W-1:0] norm_next;
    logic signed [NORM_W-1:0] norm_reg;

    function automatic div_stage_t div_step(input div_stage_t s, input logic [FIX_W-1:0] f);
        div_stage_t        r;
        logic [DIFF_W-1:0] trial;
        r     = s;
        trial = {s.rem[FIX_W-1:0], s.low[1]};
        r.low = {s.low[0], 1'b0};
        if (trial >= {1'b0, f})
        begin
            r.rem = trial - {1'b0, f};
            r.quo = {s.quo[DIV_STEPS-2:0], 1'b1};
        end
        else
        begin
            r.rem = trial;
            r.quo = {s.quo[DIV_STEPS-2:0], 1'b0};
        end
        return r;
    endfunction

    always_comb
    begin
        diff           = $signed(DIFF_W'({pixel, 8'h00})) - $signed({1'b0, centre});
        mag            = diff[DIFF_W-1] ? $unsigned(-diff) : $unsigned(diff);
        stage_next.rem = mag >> 2;
        stage_next.low = mag[1:0];
        stage_next.quo = '0;
        stage_next.neg = diff[DIFF_W-1];
        stage_next.ovf = {1'b0, mag} >= {focal, 2'b00};
    end

    always_comb
    begin
        mag_q     = stage_reg[DIV_STEPS].ovf ? NORM_W'(NORM_MAX)
                                             : NORM_W'(stage_reg[DIV_STEPS].quo);
        norm_next = stage_reg[DIV_STEPS].neg ? -$signed(mag_q) : $signed(mag_q);
    end

    always_ff @(posedge clk)
    begin
        stage_reg[0] <= stage_next;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            stage_reg[k+1] <= div_step(stage_reg[k], focal);
        end
        norm_reg <= norm_next;
    end

    assign norm = norm_reg;

endmodule

// ===== dv/lens_undistort_remap_tb.sv =====
module lens_undistort_remap_tb;
    import lur_pkg::*;

    localparam int FW = FRAME_WIDTH_DEF;
    localparam int FH = FRAME_HEIGHT_DEF;

    typedef struct {
        kind_e           kind;
        bit [COL_W-1:0]  col;
        bit [ROW_W-1:0]  row;
        bit [VAL_W-1:0]  val;
        bit              has_result;
        bit              src_in;
        bit [VAL_W-1:0]  nearest;
        bit [VAL_W-1:0]  mean;
    } pixel_word_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 kind = 1'b0;
    logic [COL_W-1:0]     pixel_col = '0;
    logic [ROW_W-1:0]     pixel_row = '0;
    logic [VAL_W-1:0]     pixel_value = '0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COEF_W-1:0]    cfg_data = '0;
    logic                 done;
    logic                 source_inside;
    logic [VAL_W-1:0]     nearest_value;
    logic [VAL_W-1:0]     mean_value;

    pixel_word_t pending_q[$];
    pixel_word_t remap_q[$];
    pixel_word_t in_flight;
    int          idle_pct = 0;
    int          fail_cnt = 0;

    bit [7:0] frame_mem [FW*FH];
    bit       loaded [FW*FH];
    longint   k1 = 0, k2 = 0, p1 = 0, p2 = 0;
    longint   fx = 117415, fy = 117068, cx = 94007, cy = 63584;

    lens_undistort_remap u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .pixel_col(pixel_col), .pixel_row(pixel_row), .pixel_value(pixel_value),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .done(done), .source_inside(source_inside),
        .nearest_value(nearest_value), .mean_value(mean_value)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("FAIL");
        $finish;
    end

    function automatic longint clamp_sym(longint a, longint lim);
        if (a > lim)
            return lim;
        if (a < -lim)
            return -lim;
        return a;
    endfunction

    function automatic void map_source(input int col, input int row, output bit ins,
                                       output int sc, output int sr);
        longint f_x, f_y, x, y, x2, y2, xy, r2, rad, xd, yd, ud, vd;
        f_x = (fx == 0) ? 1 : fx;
        f_y = (fy == 0) ? 1 : fy;
        x = clamp_sym(((longint'(col) * 256 - cx) * 16777216) / f_x, (longint'(1) << 26) - 1);
        y = clamp_sym(((longint'(row) * 256 - cy) * 16777216) / f_y, (longint'(1) << 26) - 1);
        x2 = (x * x) >>> 24;
        y2 = (y * y) >>> 24;
        xy = (x * y) >>> 24;
        r2 = x2 + y2;
        rad = (longint'(1) << 24) + ((k1 * r2) >>> 28) + ((((k2 * r2) >>> 28) * r2) >>> 24);
        rad = clamp_sym(rad, longint'(1) << 36);
        xd = ((x * rad) >>> 24) + 2 * ((p1 * xy) >>> 28) + ((p2 * (r2 + 2 * x2)) >>> 28);
        yd = ((y * rad) >>> 24) + ((p1 * (r2 + 2 * y2)) >>> 28) + 2 * ((p2 * xy) >>> 28);
        ud = f_x * xd + cx * 16777216;
        vd = f_y * yd + cy * 16777216;
        ins = !(ud < 0 || vd < 0 || ud >= (longint'(FW) << 32) || vd >= (longint'(FH) << 32));
        sc = ins ? int'(ud >>> 32) : 0;
        sr = ins ? int'(vd >>> 32) : 0;
    endfunction

    task automatic add_load(int col, int row, int val);
        pixel_word_t w;
        w = '{KIND_LOAD, COL_W'(col), ROW_W'(row), VAL_W'(val), 1'b0, 1'b0, '0, '0};
        if (col < FW && row < FH)
        begin
            frame_mem[row*FW + col] = VAL_W'(val);
            loaded[row*FW + col] = 1'b1;
        end
        pending_q.push_back(w);
    endtask

    task automatic add_compute(int col, int row);
        pixel_word_t w;
        bit          ins;
        int          sc, sr, c1, r1, sum;
        int          cs[4], rs[4];
        map_source(col, row, ins, sc, sr);
        w = '{KIND_COMPUTE, COL_W'(col), ROW_W'(row), VAL_W'($urandom_range(0, 255)),
              1'b1, ins, '0, '0};
        if (ins)
        begin
            c1 = (sc + 1 < FW) ? sc + 1 : FW - 1;
            r1 = (sr + 1 < FH) ? sr + 1 : FH - 1;
            cs = '{sc, c1, sc, c1};
            rs = '{sr, sr, r1, r1};
            sum = 0;
            for (int i = 0; i < 4; i++)
            begin
                if (!loaded[rs[i]*FW + cs[i]] || $urandom_range(0, 99) < 25)
                    add_load(cs[i], rs[i], $urandom_range(0, 3) == 0 ? 255 : $urandom_range(0, 255));
                sum += frame_mem[rs[i]*FW + cs[i]];
            end
            w.nearest = frame_mem[sr*FW + sc];
            w.mean = VAL_W'(sum / 4);
        end
        pending_q.push_back(w);
    endtask

    task automatic gen_random(int n);
        int r;
        int stop;
        stop = pending_q.size() + n;
        while (pending_q.size() < stop)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                if ($urandom_range(0, 1))
                    add_load($urandom_range(FW, 1023), $urandom_range(0, 511), $urandom_range(0, 255));
                else
                    add_load($urandom_range(0, 1023), $urandom_range(FH, 511), $urandom_range(0, 255));
            end
            else if (r < 14)
                add_load($urandom_range(0, FW-1), $urandom_range(0, FH-1), $urandom_range(0, 255));
            else if (r < 24)
                add_compute($urandom_range(0, 1023), $urandom_range(0, 511));
            else
                add_compute($urandom_range(0, FW-1), $urandom_range(0, FH-1));
        end
    endtask

    task automatic cfg_write(cfg_idx_e idx, bit [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_K1: k1 = longint'($signed(data));
            REG_K2: k2 = longint'($signed(data));
            REG_P1: p1 = longint'($signed(data));
            REG_P2: p2 = longint'($signed(data));
            REG_FX: fx = longint'(data[19:0]);
            REG_FY: fy = longint'(data[19:0]);
            REG_CX: cx = longint'(data[19:0]);
            REG_CY: cy = longint'(data[19:0]);
            default: ;
        endcase
    endtask

    task automatic cfg_all(bit [31:0] a, bit [31:0] b, bit [31:0] c, bit [31:0] d,
                           bit [31:0] e, bit [31:0] f, bit [31:0] g, bit [31:0] h);
        cfg_write(REG_K1, a);
        cfg_write(REG_K2, b);
        cfg_write(REG_P1, c);
        cfg_write(REG_P2, d);
        cfg_write(REG_FX, e);
        cfg_write(REG_FY, f);
        cfg_write(REG_CX, g);
        cfg_write(REG_CY, h);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        do @(posedge clk);
        while (pending_q.size() != 0 || start || remap_q.size() != 0);
        repeat (60) @(posedge clk);
    endtask

    task automatic report(string what, int got, int want);
        fail_cnt++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy && in_flight.has_result)
                remap_q.push_back(in_flight);
            if (!start || !busy)
            begin
                if (pending_q.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    in_flight = pending_q.pop_front();
                    start <= 1'b1;
                    kind <= in_flight.kind;
                    pixel_col <= in_flight.col;
                    pixel_row <= in_flight.row;
                    pixel_value <= in_flight.val;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        pixel_word_t e;
        if (rst_n && done)
        begin
            if (remap_q.size() == 0)
                report("unexpected result", 1, 0);
            else
            begin
                e = remap_q.pop_front();
                if (source_inside !== e.src_in)
                    report("source_inside", source_inside, e.src_in);
                if (nearest_value !== e.nearest)
                    report("nearest_value", nearest_value, e.nearest);
                if (mean_value !== e.mean)
                    report("mean_value", mean_value, e.mean);
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // corners, out-of-frame loads and requests under reset settings
        add_load(FW-1, FH-1, 255);
        add_load(0, 0, 0);
        add_load(1023, 511, 255);
        add_load(FW, 0, 170);
        add_load(0, FH, 85);
        add_compute(0, 0);
        add_compute(FW-1, FH-1);
        add_compute(1023, 511);
        add_compute(FW-1, 0);
        add_compute(0, FH-1);
        add_compute(367, 248);
        gen_random(120);
        wait_drain();

        idle_pct = 65;
        cfg_all(-32'sd53687091, 32'sd13421772, 32'sd268435, -32'sd402653,
                117415, 117068, 94007, 63584);
        gen_random(130);
        wait_drain();

        idle_pct = 16;
        cfg_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h000F_FFFF, 32'h0, 32'h0, 32'h000F_FFFF);
        add_compute(0, 0);
        add_compute(FW-1, FH-1);
        gen_random(120);
        wait_drain();

        idle_pct = 65;
        cfg_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        gen_random(120);
        wait_drain();

        idle_pct = 0;
        cfg_all(32'h0, 32'h0, 32'h0, 32'h0, 32'h0000_0001, 32'hFFF0_0000, 32'h0, 32'h0);
        gen_random(100);
        wait_drain();

        idle_pct = 30;
        cfg_all($urandom_range(0, 1 << 26) - (1 << 25), $urandom_range(0, 1 << 24) - (1 << 23),
                $urandom_range(0, 1 << 20) - (1 << 19), $urandom_range(0, 1 << 20) - (1 << 19),
                $urandom_range(60000, 200000), $urandom_range(60000, 200000),
                $urandom_range(0, 163840), $urandom_range(0, 122880));
        gen_random(130);
        wait_drain();

        if (fail_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/lur_pkg.sv
rtl/core/lur_norm.sv
rtl/core/lens_undistort_remap.sv
dv/lens_undistort_remap_tb.sv
